/* rtl/adp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// adp_pkg
// Shared types and constants of the Art-Net DMX packet parser.
// ----------------------------------------------------------------------------
package adp_pkg;

  localparam int unsigned IdLen = 7;

  localparam logic [9:0] HDR_LEN      = 10'd18;
  localparam logic [9:0] POS_OP_LO    = 10'd8;
  localparam logic [9:0] POS_OP_HI    = 10'd9;
  localparam logic [9:0] POS_UNI_LO   = 10'd14;
  localparam logic [9:0] POS_UNI_HI   = 10'd15;
  localparam logic [9:0] POS_LEN_HI   = 10'd16;
  localparam logic [9:0] POS_LEN_LO   = 10'd17;
  localparam logic [9:0] POS_ID_END   = 10'd7;

  localparam logic [15:0] OP_DMX  = 16'h5000;
  localparam logic [15:0] OP_POLL = 16'h2000;

  localparam logic KIND_CHANNEL = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic [2:0] ST_DMX_OK    = 3'd0;
  localparam logic [2:0] ST_POLL      = 3'd1;
  localparam logic [2:0] ST_TOO_SHORT = 3'd2;
  localparam logic [2:0] ST_BAD_ID    = 3'd3;
  localparam logic [2:0] ST_OTHER_OP  = 3'd4;

  localparam logic [7:0] ID_TEXT [IdLen] = '{8'h41, 8'h72, 8'h74, 8'h2D, 8'h4E, 8'h65, 8'h74};

  typedef struct packed {
    logic        result_kind;
    logic [2:0]  packet_status;
    logic [15:0] dmx_universe;
    logic [8:0]  channel_index;
    logic [7:0]  channel_value;
    logic        last_of_run;
  } result_t;

endpackage
`default_nettype wire

/* rtl/adp_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// adp_if
// Valid/ready channels of the parser: payload bytes in, results out.
// ----------------------------------------------------------------------------
interface adp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       end_of_datagram;

  modport source (output valid, output payload_byte, output end_of_datagram, input ready);
  modport sink (input valid, input payload_byte, input end_of_datagram, output ready);
endinterface

interface adp_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [2:0]  packet_status;
  logic [15:0] dmx_universe;
  logic [8:0]  channel_index;
  logic [7:0]  channel_value;
  logic        last_of_run;

  modport source (output valid, output result_kind, output packet_status,
                  output dmx_universe, output channel_index, output channel_value,
                  output last_of_run, input ready);
  modport sink (input valid, input result_kind, input packet_status,
                input dmx_universe, input channel_index, input channel_value,
                input last_of_run, output ready);
endinterface
`default_nettype wire

/* rtl/artnet_dmx_packet_parser_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// artnet_dmx_packet_parser_top
// Streaming Art-Net OpDmx receive parser with a small result queue.
// ----------------------------------------------------------------------------
// The in_i channel takes one UDP payload byte per beat; end_of_datagram marks
// the last byte of a datagram. Header fields are captured as they pass. For a
// valid OpDmx datagram every data byte inside the channel bound yields one
// channel result on out_o, tagged with universe and channel index. The last
// byte of each datagram yields a status result, after its channel result if
// it has one. last_of_run flags the final result caused by one input byte.
// An accepted byte is evaluated in the cycle of acceptance and its results
// are written into a four-entry result queue, so results reach out_o from
// the registered queue in order. The queue head drives out_o.
// A byte is taken whenever the queue has room for two results, which lets
// one byte per cycle through while the receiver keeps up; a byte that
// yields two results sends both out in order. When the receiver stalls,
// in_i.ready drops once three results wait, which from an empty queue takes
// at most three more bytes that yield results; header bytes keep flowing.
// Reset empties the queue and returns the parser to the start of a datagram.
// ----------------------------------------------------------------------------
module artnet_dmx_packet_parser_top
  import adp_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 512
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  adp_in_if.sink    in_i,
  adp_out_if.source out_o
);

  localparam logic [9:0] MaxCh = 10'(MAX_CHANNELS);

  logic [9:0]  pos_q, pos_d;
  logic        id_ok_q, id_ok_d;
  logic [15:0] opcode_q, opcode_d;
  logic [15:0] universe_q, universe_d;
  logic [15:0] dlen_q, dlen_d;

  logic        in_acc, out_acc;
  logic [9:0]  ch;
  logic        chan_hit;
  logic        eod;
  logic [2:0]  status;
  result_t     chan_res, stat_res, res0, res1;
  logic        push0, push1;

  result_t     fifo_q [4];
  logic [1:0]  wr_ptr_q, rd_ptr_q;
  logic [2:0]  count_q, count_d;

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;
  assign eod     = in_i.end_of_datagram;
  assign ch      = pos_q - HDR_LEN;

  always_comb begin
    pos_d      = pos_q;
    id_ok_d    = id_ok_q;
    opcode_d   = opcode_q;
    universe_d = universe_q;
    dlen_d     = dlen_q;
    chan_hit   = 1'b0;
    if (pos_q < POS_ID_END) begin
      if (in_i.payload_byte != ID_TEXT[pos_q[2:0]]) begin
        id_ok_d = 1'b0;
      end
    end else if (pos_q == POS_OP_LO) begin
      opcode_d[7:0] = in_i.payload_byte;
    end else if (pos_q == POS_OP_HI) begin
      opcode_d[15:8] = in_i.payload_byte;
    end else if (pos_q == POS_UNI_LO) begin
      universe_d[7:0] = in_i.payload_byte;
    end else if (pos_q == POS_UNI_HI) begin
      universe_d[15:8] = in_i.payload_byte;
    end else if (pos_q == POS_LEN_HI) begin
      dlen_d[15:8] = in_i.payload_byte;
    end else if (pos_q == POS_LEN_LO) begin
      dlen_d[7:0] = in_i.payload_byte;
    end else if (pos_q >= HDR_LEN) begin
      chan_hit = id_ok_q && (opcode_q == OP_DMX) && ({6'd0, ch} < dlen_q) && (ch < MaxCh);
    end

    if (pos_q < HDR_LEN - 10'd1) begin
      status = ST_TOO_SHORT;
    end else if (!id_ok_q) begin
      status = ST_BAD_ID;
    end else if (opcode_q == OP_POLL) begin
      status = ST_POLL;
    end else if (opcode_q != OP_DMX) begin
      status = ST_OTHER_OP;
    end else begin
      status = ST_DMX_OK;
    end

    if (eod) begin
      pos_d      = '0;
      id_ok_d    = 1'b1;
      opcode_d   = '0;
      universe_d = '0;
      dlen_d     = '0;
    end else if (!(&pos_q)) begin
      pos_d = pos_q + 10'd1;
    end

    chan_res.result_kind   = KIND_CHANNEL;
    chan_res.packet_status = ST_DMX_OK;
    chan_res.dmx_universe  = universe_q;
    chan_res.channel_index = ch[8:0];
    chan_res.channel_value = in_i.payload_byte;
    chan_res.last_of_run   = !eod;

    stat_res.result_kind   = KIND_STATUS;
    stat_res.packet_status = status;
    stat_res.dmx_universe  = (status == ST_DMX_OK) ? universe_q : 16'd0;
    stat_res.channel_index = '0;
    stat_res.channel_value = '0;
    stat_res.last_of_run   = 1'b1;

    res0  = chan_hit ? chan_res : stat_res;
    res1  = stat_res;
    push0 = in_acc && (chan_hit || eod);
    push1 = in_acc && chan_hit && eod;

    count_d = count_q + {2'd0, push0} + {2'd0, push1} - {2'd0, out_acc};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      id_ok_q    <= 1'b1;
      opcode_q   <= '0;
      universe_q <= '0;
      dlen_q     <= '0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      count_q    <= '0;
    end else begin
      if (in_acc) begin
        pos_q      <= pos_d;
        id_ok_q    <= id_ok_d;
        opcode_q   <= opcode_d;
        universe_q <= universe_d;
        dlen_q     <= dlen_d;
      end
      wr_ptr_q <= wr_ptr_q + {1'b0, push0} + {1'b0, push1};
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push0) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (push1) begin
      fifo_q[wr_ptr_q + 2'd1] <= res1;
    end
  end

  assign in_i.ready          = (count_q <= 3'd2);
  assign out_o.valid         = (count_q != 3'd0);
  assign out_o.result_kind   = fifo_q[rd_ptr_q].result_kind;
  assign out_o.packet_status = fifo_q[rd_ptr_q].packet_status;
  assign out_o.dmx_universe  = fifo_q[rd_ptr_q].dmx_universe;
  assign out_o.channel_index = fifo_q[rd_ptr_q].channel_index;
  assign out_o.channel_value = fifo_q[rd_ptr_q].channel_value;
  assign out_o.last_of_run   = fifo_q[rd_ptr_q].last_of_run;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 3'd4)
    else $error("Result queue count exceeds its depth.");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == 3'd0 |-> rd_ptr_q == wr_ptr_q)
    else $error("Empty result queue has unequal pointers.");

  a_eod_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && eod |=> pos_q == 10'd0 && id_ok_q && opcode_q == 16'd0)
    else $error("Parser did not restart after the end of a datagram.");

  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.result_kind == KIND_STATUS |->
      out_o.channel_index == 9'd0 && out_o.channel_value == 8'd0 && out_o.last_of_run)
    else $error("Status result carries channel data.");

  a_chan_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.result_kind == KIND_CHANNEL |-> out_o.packet_status == ST_DMX_OK)
    else $error("Channel result carries a nonzero status.");
`endif

endmodule
`default_nettype wire

/* verif/adp_result_board_pkg.sv */
// ----------------------------------------------------------------------------
// adp_result_board_pkg
// Tracks the Art-Net parser's header state for every accepted byte, queues
// the channel and status results that the byte must produce, and compares
// the results that leave the block against them in order.
// ----------------------------------------------------------------------------
package adp_result_board_pkg;

  import adp_pkg::*;

  class dmx_result_board;

    int unsigned max_channels;

    logic [9:0]  byte_pos;
    bit          id_seen_ok;
    logic [15:0] opcode;
    logic [15:0] universe;
    logic [15:0] dmx_length;

    result_t     expected_results[$];
    int          errors;
    int          channel_beats;
    int          status_count[8];

    function new(int unsigned max_ch);
      max_channels = max_ch;
      errors = 0;
      channel_beats = 0;
      foreach (status_count[i]) status_count[i] = 0;
      restart();
    endfunction

    function void restart();
      byte_pos = '0;
      id_seen_ok = 1'b1;
      opcode = '0;
      universe = '0;
      dmx_length = '0;
    endfunction

    function int waiting();
      return expected_results.size();
    endfunction

    function string show(result_t r);
      return $sformatf("kind=%0d status=%0d universe=%h channel=%0d value=%h last=%0d",
                       r.result_kind, r.packet_status, r.dmx_universe,
                       r.channel_index, r.channel_value, r.last_of_run);
    endfunction

    function void note_byte(logic [7:0] value, logic last);
      result_t    r;
      logic [9:0] pos;
      logic [9:0] chan;
      pos = byte_pos;
      if (pos < POS_ID_END) begin
        if (value != ID_TEXT[pos]) id_seen_ok = 1'b0;
      end else if (pos == POS_OP_LO) begin
        opcode[7:0] = value;
      end else if (pos == POS_OP_HI) begin
        opcode[15:8] = value;
      end else if (pos == POS_UNI_LO) begin
        universe[7:0] = value;
      end else if (pos == POS_UNI_HI) begin
        universe[15:8] = value;
      end else if (pos == POS_LEN_HI) begin
        dmx_length[15:8] = value;
      end else if (pos == POS_LEN_LO) begin
        dmx_length[7:0] = value;
      end else if (pos >= HDR_LEN) begin
        chan = pos - HDR_LEN;
        if (id_seen_ok && opcode == OP_DMX && 16'(chan) < dmx_length &&
            int'(chan) < int'(max_channels)) begin
          r = '0;
          r.result_kind = KIND_CHANNEL;
          r.packet_status = ST_DMX_OK;
          r.dmx_universe = universe;
          r.channel_index = chan[8:0];
          r.channel_value = value;
          r.last_of_run = !last;
          expected_results.push_back(r);
          channel_beats++;
        end
      end
      if (last) begin
        r = '0;
        r.result_kind = KIND_STATUS;
        r.last_of_run = 1'b1;
        if (pos < HDR_LEN - 10'd1) begin
          r.packet_status = ST_TOO_SHORT;
        end else if (!id_seen_ok) begin
          r.packet_status = ST_BAD_ID;
        end else if (opcode == OP_POLL) begin
          r.packet_status = ST_POLL;
        end else if (opcode != OP_DMX) begin
          r.packet_status = ST_OTHER_OP;
        end else begin
          r.packet_status = ST_DMX_OK;
          r.dmx_universe = universe;
        end
        expected_results.push_back(r);
        status_count[r.packet_status]++;
        restart();
      end else if (byte_pos != 10'h3FF) begin
        byte_pos = byte_pos + 10'd1;
      end
    endfunction

    function void flag_error(string what, result_t want, result_t got);
      errors++;
      if (errors <= 10) begin
        $display("%t %s", $realtime, what);
        $display("  expected %s", show(want));
        $display("  actual   %s", show(got));
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        flag_error("Result beat with nothing expected.", '0, got);
      end else begin
        want = expected_results.pop_front();
        if (got.result_kind !== want.result_kind ||
            got.packet_status !== want.packet_status ||
            got.dmx_universe !== want.dmx_universe ||
            got.channel_index !== want.channel_index ||
            got.channel_value !== want.channel_value ||
            got.last_of_run !== want.last_of_run) begin
          flag_error("Result beat mismatch.", want, got);
        end
      end
    endfunction

  endclass

endpackage

/* verif/artnet_dmx_packet_parser_top_test.sv */
// ----------------------------------------------------------------------------
// artnet_dmx_packet_parser_top_test
// Sends directed and random Art-Net datagrams byte by byte through the
// parser, with random gaps on both sides and long output stalls, and checks
// every channel and status result against a tracked copy of the header state.
// ----------------------------------------------------------------------------
module artnet_dmx_packet_parser_top_test;

  timeunit 1ns;
  timeprecision 1ps;

  import adp_pkg::*;
  import adp_result_board_pkg::*;

  localparam int unsigned MaxChannels = 512;

  logic clk_i;
  logic rst_ni;

  adp_in_if  in_bus ();
  adp_out_if out_bus ();

  artnet_dmx_packet_parser_top #(
    .MAX_CHANNELS(MaxChannels)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  dmx_result_board tracker = new(MaxChannels);

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_cycles = 0;
  int          bytes_sent = 0;
  int          datagrams_sent = 0;
  logic [7:0]  frame[$];

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results still expected.", tracker.waiting());
    $display("Regression FAIL");
    $finish;
  end

  initial begin : result_sink
    result_t got;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_bus.valid && out_bus.ready) begin
        got.result_kind = out_bus.result_kind;
        got.packet_status = out_bus.packet_status;
        got.dmx_universe = out_bus.dmx_universe;
        got.channel_index = out_bus.channel_index;
        got.channel_value = out_bus.channel_value;
        got.last_of_run = out_bus.last_of_run;
        tracker.check_result(got);
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] value, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_bus.valid <= 1'b1;
    in_bus.payload_byte <= value;
    in_bus.end_of_datagram <= last;
    do @(posedge clk_i); while (!in_bus.ready);
    tracker.note_byte(value, last);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
    datagrams_sent++;
  endtask

  // A cut between 1 and 17 truncates the header to make a runt datagram.
  task automatic send_datagram(input bit id_good, input logic [15:0] op,
                               input logic [15:0] uni, input logic [15:0] len,
                               input int data_bytes, input int cut);
    int bad_pos;
    frame.delete();
    for (int i = 0; i < IdLen; i++) frame.push_back(ID_TEXT[i]);
    if (!id_good) begin
      bad_pos = $urandom_range(0, IdLen - 1);
      frame[bad_pos] = frame[bad_pos] ^ 8'($urandom_range(1, 255));
    end
    frame.push_back(8'($urandom));
    frame.push_back(op[7:0]);
    frame.push_back(op[15:8]);
    for (int i = 0; i < 4; i++) frame.push_back(8'($urandom));
    frame.push_back(uni[7:0]);
    frame.push_back(uni[15:8]);
    frame.push_back(len[15:8]);
    frame.push_back(len[7:0]);
    for (int i = 0; i < data_bytes; i++) frame.push_back(8'($urandom));
    if (cut > 0 && cut < frame.size()) frame = frame[0:cut-1];
    send_frame();
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    do @(posedge clk_i); while (tracker.waiting() != 0);
  endtask

  initial begin : stimulus
    int pick;
    int size_pick;
    int len_cap;
    int target;
    logic [15:0] len;
    rst_ni = 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.payload_byte <= '0;
    in_bus.end_of_datagram <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_datagram(1, OP_DMX, 16'h0000, 16'd0, 0, 1);
    send_datagram(1, OP_DMX, 16'h1234, 16'd3, 0, 17);
    send_datagram(0, OP_POLL, 16'h0000, 16'd0, 0, 10);
    send_datagram(1, OP_DMX, 16'h0000, 16'd0, 0, 0);
    send_datagram(1, OP_DMX, 16'hFFFF, 16'd3, 3, 0);
    send_datagram(1, OP_DMX, 16'h00A5, 16'd2, 6, 0);
    send_datagram(1, OP_DMX, 16'h5A00, 16'd10, 4, 0);
    send_datagram(1, OP_POLL, 16'h0101, 16'd4, 4, 0);
    send_datagram(1, 16'h0050, 16'h0001, 16'd4, 4, 0);
    send_datagram(1, 16'hFFFF, 16'h8000, 16'hFFFF, 2, 0);
    send_datagram(0, OP_POLL, 16'h0000, 16'd0, 2, 0);
    send_datagram(0, OP_DMX, 16'h0001, 16'd4, 4, 0);
    send_datagram(1, OP_DMX, 16'hFFFF, 16'hFFFF, 1100, 0);
    send_datagram(1, OP_DMX, 16'h7E7E, 16'd512, 513, 0);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 60 : 0;
      recv_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 20 : 0;
      target = bytes_sent + 150;
      if (phase != 1) begin
        hold_cycles = 300;
        send_datagram(1, OP_DMX, 16'($urandom), 16'd80, 80, 0);
      end
      while (bytes_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          size_pick = $urandom_range(99);
          if (size_pick < 3) begin
            len = (size_pick == 0) ? 16'd511 : (size_pick == 1) ? 16'd513 : 16'hFFFF;
            send_datagram(1, OP_DMX, 16'($urandom), len, $urandom_range(500, 530), 0);
          end else begin
            len = (size_pick < 25) ? 16'($urandom) : 16'($urandom_range(0, 40));
            len_cap = (len > 40) ? 40 : int'(len);
            send_datagram(1, OP_DMX, 16'($urandom), len,
                          $urandom_range(0, len_cap + 4), 0);
          end
        end else if (pick < 70) begin
          send_datagram(1, OP_POLL, 16'($urandom), 16'($urandom),
                        $urandom_range(0, 8), 0);
        end else if (pick < 78) begin
          send_datagram(1, 16'($urandom), 16'($urandom), 16'($urandom),
                        $urandom_range(0, 8), 0);
        end else if (pick < 88) begin
          send_datagram(0, ($urandom_range(1) != 0) ? OP_DMX : OP_POLL,
                        16'($urandom), 16'($urandom_range(0, 20)),
                        $urandom_range(0, 8), 0);
        end else if (pick < 94) begin
          send_datagram(1, OP_DMX, 16'($urandom), 16'($urandom), 0,
                        $urandom_range(1, 17));
        end else begin
          frame.delete();
          repeat ($urandom_range(1, 30)) frame.push_back(8'($urandom));
          send_frame();
        end
      end
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    $display("Sent %0d datagrams in %0d input beats; checked %0d channel beats.",
             datagrams_sent, bytes_sent, tracker.channel_beats);
    $display("Status beats: ok %0d, poll %0d, too short %0d, bad id %0d, other %0d.",
             tracker.status_count[ST_DMX_OK], tracker.status_count[ST_POLL],
             tracker.status_count[ST_TOO_SHORT], tracker.status_count[ST_BAD_ID],
             tracker.status_count[ST_OTHER_OP]);
    if (tracker.errors == 0 && tracker.waiting() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results still expected.",
               tracker.errors, tracker.waiting());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
